[rtl/hav_pkg.sv]
// Shared constants, types and elaboration-time table functions for the haversine pipeline.
`default_nettype none

package hav_pkg;

    // Fixed-point format and CORDIC depth
    localparam int FRAC_BITS     = 30;
    localparam int CORDIC_STAGES = 30;

    // Datapath widths derived from the format
    localparam int CW        = FRAC_BITS + 4;
    localparam int SHW       = $clog2(CORDIC_STAGES);
    localparam int HW        = FRAC_BITS + 1;
    localparam int RADW      = 2 * FRAC_BITS + 2;
    localparam int REMW      = FRAC_BITS + 4;
    localparam int ROOTW     = FRAC_BITS + 2;
    localparam int SQ_STAGES = FRAC_BITS + 1;
    localparam int UW        = 35;
    localparam int DIST_W    = 25;

    // Angle units of 0.5e-7 degree
    localparam logic signed [UW-1:0] PI_U       = 35'sd3600000000;
    localparam logic signed [UW-1:0] NPI_U      = -35'sd3600000000;
    localparam logic signed [UW-1:0] HALF_PI_U  = 35'sd1800000000;
    localparam logic signed [UW-1:0] NHALF_PI_U = -35'sd1800000000;
    localparam logic signed [UW-1:0] TWO_PI_U   = 35'sd7200000000;

    // Scale factors
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] DEG_Q93 = 64'd17284903702238269500;
    localparam logic [38:0] R_Q16   = 39'd417647660948;

    typedef logic signed [CW-1:0] t_cval;

    // One CORDIC word: vector, residual angle and a side flag
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flag;
    } t_cord;

    // Per-cell control: mode, shift and arctangent step
    typedef struct packed {
        logic                 vec;
        logic [SHW-1:0]       shift;
        logic signed [CW-1:0] atan;
    } t_cord_ctl;

    // One square-root word: remaining radicand, partial remainder, partial root
    typedef struct packed {
        logic [RADW-1:0]  rad;
        logic [REMW-1:0]  rem;
        logic [ROOTW-1:0] root;
    } t_root;

    // Restoring long division, used only on constants
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i in Q62 by its series
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] acc;
        logic [63:0] t;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q62 >> 2;
        end else begin
            for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
                t = long_div(64'd1 << (62 - (2 * k + 1) * i), 64'(2 * k + 1));
                if (k[0]) begin
                    acc = acc - t;
                end else begin
                    acc = acc + t;
                end
            end
        end
        return acc;
    endfunction

    // Arctangent step rounded to the working format
    function automatic logic signed [CW-1:0] atan_fix(input int i);
        logic [63:0] r;
        r = (atan_q62(i) + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
        return $signed(r[CW-1:0]);
    endfunction

    // Start value 1/G for rotation, G being the CORDIC gain
    function automatic logic signed [CW-1:0] kinv();
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] at;
        logic [63:0]        g;
        logic [63:0]        r;
        logic [63:0]        q;
        gx = 64'sd1 <<< FRAC_BITS;
        gy = '0;
        z  = '0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            at = 64'(atan_fix(i));
            dx = gy >>> i;
            dy = gx >>> i;
            if (!z[63]) begin
                gx = gx - dx;
                gy = gy + dy;
                z  = z - at;
            end else begin
                gx = gx + dx;
                gy = gy - dy;
                z  = z + at;
            end
        end
        g = gx;
        r = 64'd1 << FRAC_BITS;
        q = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q = q | 64'd1;
            end
        end
        return $signed(q[CW-1:0]);
    endfunction

endpackage

`default_nettype wire

[rtl/haversine_distance.sv]
// Throughput: one word per cycle; every stage is a register, CORDIC and root cells included.
// The whole pipeline holds while an output word waits for tready; input tready follows.
// Reset (synchronous, active low) clears the stage valid bits; data registers are not reset.
// Top level of the haversine great-circle distance pipeline.
`default_nettype none

module haversine_distance (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output      logic         o_s_axis_tready,
    // first_lat[30:0], first_lon[62:31], second_lat[93:63], second_lon[125:94], zero[127:126]
    input  wire logic [127:0] i_s_axis_tdata,
    output      logic         o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // distance_m[24:0], zero[31:25]
    output      logic [31:0]  o_m_axis_tdata
);
    import hav_pkg::*;

    localparam int N      = CORDIC_STAGES;
    localparam int D      = 2 * N + FRAC_BITS + 13;
    localparam int IDX_H  = N + 8;
    localparam int AW     = FRAC_BITS + 3;
    localparam int MSW    = AW + 40;
    localparam int QW     = MSW - FRAC_BITS - 16;
    localparam t_cval K_INIT = kinv();
    localparam logic signed [CW+1:0] ONE_H = (CW+2)'(1) <<< FRAC_BITS;

    function automatic logic [CW-1:0] mag_of(input t_cval v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    logic                   w_en;
    logic [D-1:0]           r_vld;

    logic signed [UW-1:0]   w_lat1;
    logic signed [UW-1:0]   w_lon1;
    logic signed [UW-1:0]   w_lat2;
    logic signed [UW-1:0]   w_lon2;
    logic signed [UW-1:0]   r_u1 [4];
    logic signed [UW-1:0]   r_u2 [4];
    logic signed [UW-1:0]   w_fold [4];
    logic                   w_flip [4];
    logic [30:0]            r_mag3 [4];
    logic                   r_neg3 [4];
    logic                   r_flip3 [4];
    logic [62:0]            r_phi4 [4];
    logic [62:0]            r_plo4 [4];
    logic                   r_neg4 [4];
    logic                   r_flip4 [4];
    logic [95:0]            w_sum5 [4];
    logic [FRAC_BITS+1:0]   r_rad5 [4];
    logic                   r_neg5 [4];
    logic                   r_flip5 [4];

    t_cord                  w_rot [4][N+1];

    logic [CW-1:0]          r_ma;
    logic [CW-1:0]          r_mb;
    logic [CW-1:0]          r_m1;
    logic [CW-1:0]          r_m2;
    logic                   r_neg6;
    logic [2*CW-1:0]        w_paa;
    logic [2*CW-1:0]        w_pbb;
    logic [2*CW-1:0]        w_pcc;
    logic [CW-1:0]          r_aa7;
    logic [CW-1:0]          r_bb7;
    logic [CW-1:0]          r_cc7;
    logic                   r_neg7;
    logic [2*CW-1:0]        w_pt;
    logic [CW-1:0]          r_aa8;
    logic [CW-1:0]          r_t8;
    logic                   r_neg8;
    logic signed [CW+1:0]   w_ts;
    logic signed [CW+1:0]   w_hs;
    logic [HW-1:0]          r_h;
    logic [HW-1:0]          w_h1;
    t_root                  r_sqin [2];

    t_root                  w_sq [2][SQ_STAGES+1];
    t_cord                  w_vec [N+1];

    t_cval                  w_zf;
    logic [AW-1:0]          w_ang;
    logic [AW+18:0]         r_phim;
    logic [AW+19:0]         r_plom;
    logic [MSW-1:0]         w_msum;
    logic [QW-1:0]          w_q;
    logic [DIST_W-1:0]      r_out;

    // Whole pipeline moves unless the output word is held
    assign w_en            = !r_vld[D-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[D-1];
    assign o_m_axis_tdata  = {(32-DIST_W)'(0), r_out};

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-2:0], i_s_axis_tvalid};
        end
    end

    // Unpack the input word
    assign w_lat1 = UW'($signed(i_s_axis_tdata[30:0]));
    assign w_lon1 = UW'($signed(i_s_axis_tdata[62:31]));
    assign w_lat2 = UW'($signed(i_s_axis_tdata[93:63]));
    assign w_lon2 = UW'($signed(i_s_axis_tdata[125:94]));

    // Form half-unit angles: lat difference, lon difference, both latitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u1[0] <= w_lat2 - w_lat1;
            r_u1[1] <= w_lon2 - w_lon1;
            r_u1[2] <= w_lat1 <<< 1;
            r_u1[3] <= w_lat2 <<< 1;
        end
    end

    // Wrap once into [-pi, pi]
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                if (r_u1[j] > PI_U) begin
                    r_u2[j] <= r_u1[j] - TWO_PI_U;
                end else if (r_u1[j] < NPI_U) begin
                    r_u2[j] <= r_u1[j] + TWO_PI_U;
                end else begin
                    r_u2[j] <= r_u1[j];
                end
            end
        end
    end

    // Fold about +-pi/2, cosine negated on a fold
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (r_u2[j] > HALF_PI_U) begin
                w_fold[j] = PI_U - r_u2[j];
                w_flip[j] = 1'b1;
            end else if (r_u2[j] < NHALF_PI_U) begin
                w_fold[j] = NPI_U - r_u2[j];
                w_flip[j] = 1'b1;
            end else begin
                w_fold[j] = r_u2[j];
                w_flip[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                r_mag3[j]  <= w_fold[j][UW-1] ? 31'(-w_fold[j]) : 31'(w_fold[j]);
                r_neg3[j]  <= w_fold[j][UW-1];
                r_flip3[j] <= w_flip[j];
            end
        end
    end

    // Scale to radians: two 32-bit partial products of the degree factor
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                r_phi4[j]  <= 63'(r_mag3[j]) * 63'(DEG_Q93[63:32]);
                r_plo4[j]  <= 63'(r_mag3[j]) * 63'(DEG_Q93[31:0]);
                r_neg4[j]  <= r_neg3[j];
                r_flip4[j] <= r_flip3[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_sum5[j] = 96'({r_phi4[j], 32'd0}) + 96'(r_plo4[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                r_rad5[j]  <= w_sum5[j][94-FRAC_BITS +: FRAC_BITS+2];
                r_neg5[j]  <= r_neg4[j];
                r_flip5[j] <= r_flip4[j];
            end
        end
    end

    // Four sine/cosine chains
    for (genvar gj = 0; gj < 4; gj++) begin : g_chain
        assign w_rot[gj][0].x    = K_INIT;
        assign w_rot[gj][0].y    = '0;
        assign w_rot[gj][0].z    = r_neg5[gj] ? -$signed(CW'(r_rad5[gj]))
                                              : $signed(CW'(r_rad5[gj]));
        assign w_rot[gj][0].flag = r_flip5[gj];
        for (genvar gi = 0; gi < N; gi++) begin : g_cell
            localparam t_cord_ctl CTL = '{vec: 1'b0, shift: SHW'(gi), atan: atan_fix(gi)};
            hav_cordic_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_ctl (CTL),
                .i_d   (w_rot[gj][gi]),
                .o_d   (w_rot[gj][gi+1])
            );
        end
    end

    // Take magnitudes; sign of the cosine product kept apart
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ma   <= mag_of(w_rot[0][N].y);
            r_mb   <= mag_of(w_rot[1][N].y);
            r_m1   <= mag_of(w_rot[2][N].x);
            r_m2   <= mag_of(w_rot[3][N].x);
            r_neg6 <= w_rot[2][N].x[CW-1] ^ w_rot[2][N].flag
                    ^ w_rot[3][N].x[CW-1] ^ w_rot[3][N].flag;
        end
    end

    // Squares and the cosine product, truncated
    assign w_paa = (2*CW)'(r_ma) * (2*CW)'(r_ma);
    assign w_pbb = (2*CW)'(r_mb) * (2*CW)'(r_mb);
    assign w_pcc = (2*CW)'(r_m1) * (2*CW)'(r_m2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa7  <= w_paa[FRAC_BITS +: CW];
            r_bb7  <= w_pbb[FRAC_BITS +: CW];
            r_cc7  <= w_pcc[FRAC_BITS +: CW];
            r_neg7 <= r_neg6;
        end
    end

    // Cosine product times the longitude term
    assign w_pt = (2*CW)'(r_cc7) * (2*CW)'(r_bb7);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa8  <= r_aa7;
            r_t8   <= w_pt[FRAC_BITS +: CW];
            r_neg8 <= r_neg7;
        end
    end

    // Haversine term, clamped to [0, 1]
    assign w_ts = $signed({2'b00, r_t8});
    assign w_hs = $signed({2'b00, r_aa8}) + (r_neg8 ? -w_ts : w_ts);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_hs[CW+1]) begin
                r_h <= '0;
            end else if (w_hs > ONE_H) begin
                r_h <= HW'(ONE_H);
            end else begin
                r_h <= HW'(w_hs);
            end
        end
    end

    // Load both root chains: 1 - h and h, scaled by 2^F
    assign w_h1 = HW'(ONE_H) - r_h;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqin[0].rad  <= RADW'({w_h1, FRAC_BITS'(0)});
            r_sqin[0].rem  <= '0;
            r_sqin[0].root <= '0;
            r_sqin[1].rad  <= RADW'({r_h, FRAC_BITS'(0)});
            r_sqin[1].rem  <= '0;
            r_sqin[1].root <= '0;
        end
    end

    for (genvar gk = 0; gk < 2; gk++) begin : g_root
        assign w_sq[gk][0] = r_sqin[gk];
        for (genvar gi = 0; gi < SQ_STAGES; gi++) begin : g_cell
            hav_sqrt_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_sq[gk][gi]),
                .o_d   (w_sq[gk][gi+1])
            );
        end
    end

    // Arcsine by vectoring on (sqrt(1-h), sqrt(h))
    assign w_vec[0].x    = $signed(CW'(w_sq[0][SQ_STAGES].root));
    assign w_vec[0].y    = $signed(CW'(w_sq[1][SQ_STAGES].root));
    assign w_vec[0].z    = '0;
    assign w_vec[0].flag = 1'b0;

    for (genvar gi = 0; gi < N; gi++) begin : g_asin
        localparam t_cord_ctl CTL = '{vec: 1'b1, shift: SHW'(gi), atan: atan_fix(gi)};
        hav_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ctl (CTL),
            .i_d   (w_vec[gi]),
            .o_d   (w_vec[gi+1])
        );
    end

    // Central angle, negative taken as zero; radius split into two partial products
    assign w_zf  = w_vec[N].z;
    assign w_ang = w_zf[CW-1] ? '0 : AW'({w_zf[FRAC_BITS+1:0], 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phim <= (AW+19)'(w_ang) * (AW+19)'(R_Q16[38:20]);
            r_plom <= (AW+20)'(w_ang) * (AW+20)'(R_Q16[19:0]);
        end
    end

    // Sum, truncate to meters, saturate to the field
    assign w_msum = MSW'({r_phim, 20'd0}) + MSW'(r_plom);
    assign w_q    = w_msum[MSW-1 : FRAC_BITS+16];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (|w_q[QW-1:DIST_W]) begin
                r_out <= '1;
            end else begin
                r_out <= w_q[DIST_W-1:0];
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved while output was held");

    a_h_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IDX_H] |-> (r_h <= HW'(ONE_H)))
        else $error("haversine term above one");
`endif

endmodule

`default_nettype wire

[rtl/hav_cordic_cell.sv]
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered output.
`default_nettype none

module hav_cordic_cell (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire hav_pkg::t_cord_ctl i_ctl,
    input  wire hav_pkg::t_cord    i_d,
    output hav_pkg::t_cord         o_d
);
    import hav_pkg::*;

    t_cval w_x;
    t_cval w_y;
    t_cval w_z;
    t_cval w_dx;
    t_cval w_dy;
    logic  w_pos;
    t_cord n_d;
    t_cord r_d;

    assign w_x  = i_d.x;
    assign w_y  = i_d.y;
    assign w_z  = i_d.z;
    assign w_dx = w_y >>> i_ctl.shift;
    assign w_dy = w_x >>> i_ctl.shift;

    // Turn direction: by residual angle when rotating, by y when vectoring
    assign w_pos = i_ctl.vec ? (w_y[CW-1] || (w_y == '0)) : !w_z[CW-1];

    // Apply one micro-rotation
    always_comb begin
        n_d = i_d;
        if (w_pos) begin
            n_d.x = w_x - w_dx;
            n_d.y = w_y + w_dy;
            n_d.z = w_z - i_ctl.atan;
        end else begin
            n_d.x = w_x + w_dx;
            n_d.y = w_y - w_dy;
            n_d.z = w_z + i_ctl.atan;
        end
    end

    // Advance to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

[rtl/hav_sqrt_cell.sv]
// One digit step of a shift-and-subtract square root, registered output.
`default_nettype none

module hav_sqrt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire hav_pkg::t_root i_d,
    output hav_pkg::t_root      o_d
);
    import hav_pkg::*;

    logic [REMW+1:0]  w_rem;
    logic [REMW+1:0]  w_trial;
    logic [REMW+1:0]  w_diff;
    t_root            n_d;
    t_root            r_d;

    // Bring down the next bit pair and form the trial divisor
    assign w_rem   = {i_d.rem, i_d.rad[RADW-1 -: 2]};
    assign w_trial = (REMW+2)'({i_d.root, 2'b01});
    assign w_diff  = w_rem - w_trial;

    // Keep or drop the trial subtraction
    always_comb begin
        n_d.rad = {i_d.rad[RADW-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_d.rem  = w_diff[REMW-1:0];
            n_d.root = {i_d.root[ROOTW-2:0], 1'b1};
        end else begin
            n_d.rem  = w_rem[REMW-1:0];
            n_d.root = {i_d.root[ROOTW-2:0], 1'b0};
        end
    end

    // Advance to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

[sim/haversine_checker.sv]
// Checker for the haversine distance pipeline: predicts each distance and compares it.
`timescale 1ns / 1ps

module haversine_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    // first_lat[30:0], first_lon[62:31], second_lat[93:63], second_lon[125:94], zero[127:126]
    input  wire logic [127:0] i_s_tdata,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // distance_m[24:0], zero[31:25]
    input  wire logic [31:0]  i_m_tdata,
    output      int           o_fail_count,
    output      int           o_pending
);
    import hav_pkg::*;

    localparam longint ANG_PI      = 64'sd3600000000;
    localparam longint ANG_HALF_PI = 64'sd1800000000;
    localparam longint ANG_TWO_PI  = 64'sd7200000000;
    localparam logic [63:0] DIST_SAT = 64'h1FFFFFF;

    longint atan_step [CORDIC_STAGES];
    longint rot_start;
    logic [31:0] distance_queue [$];

    // Build arctangent steps and the rotation start value once
    initial begin
        logic [63:0] acc;
        longint gx, gy, z, dx, dy;
        logic [63:0] g, r, q;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                acc = PI_Q62 >> 2;
            end else begin
                acc = '0;
                for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
                    if (k % 2 == 1) begin
                        acc = acc - ((64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1));
                    end else begin
                        acc = acc + ((64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1));
                    end
                end
            end
            atan_step[i] = longint'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
        end
        gx = 64'sd1 <<< FRAC_BITS;
        gy = 0;
        z  = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = gy >>> i;
            dy = gx >>> i;
            if (z >= 0) begin
                gx = gx - dx; gy = gy + dy; z = z - atan_step[i];
            end else begin
                gx = gx + dx; gy = gy - dy; z = z + atan_step[i];
            end
        end
        g = gx;
        r = 64'd1 << FRAC_BITS;
        q = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q = q | 64'd1;
            end
        end
        rot_start = longint'(q);
    end

    // Sine and cosine of an angle in units of 0.5e-7 degree
    function automatic void sincos_units(input longint u, output longint s, output longint c);
        logic flip;
        logic neg;
        logic [63:0] mag;
        logic [127:0] prod;
        longint ang, x, y, dx, dy;
        flip = 1'b0;
        if (u > ANG_PI) u = u - ANG_TWO_PI;
        if (u < -ANG_PI) u = u + ANG_TWO_PI;
        if (u > ANG_HALF_PI) begin
            u = ANG_PI - u; flip = 1'b1;
        end
        if (u < -ANG_HALF_PI) begin
            u = -ANG_PI - u; flip = 1'b1;
        end
        neg = u < 0;
        mag = neg ? -u : u;
        prod = {64'd0, mag} * {64'd0, DEG_Q93};
        ang = longint'(prod >> (94 - FRAC_BITS));
        if (neg) ang = -ang;
        x = rot_start;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x = x - dx; y = y + dy; ang = ang - atan_step[i];
            end else begin
                x = x + dx; y = y - dy; ang = ang + atan_step[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    // Fixed-point product truncated toward zero
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] prod;
        longint r;
        prod = {64'd0, (a < 0 ? -a : a)} * {64'd0, (b < 0 ? -b : b)};
        r = longint'(prod >> FRAC_BITS);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Floor square root of h scaled to the working format
    function automatic longint qsqrt(input logic [63:0] h);
        logic [127:0] radicand;
        logic [63:0] root, rem, trial;
        radicand = {64'd0, h} << FRAC_BITS;
        root = '0;
        rem  = '0;
        for (int k = FRAC_BITS; k >= 0; k--) begin
            rem = (rem << 2) | 64'((radicand >> (2 * k)) & 128'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    // Great-circle distance in meters for one packed word
    function automatic logic [31:0] predict_distance(input logic [127:0] w);
        longint lat1, lon1, lat2, lon2;
        longint sa, ca, sb, cb, s1, c1, s2, c2, h, vx, vy, vz, dx, dy, ang;
        longint one;
        logic [127:0] prod;
        logic [63:0] meters;
        one  = 64'sd1 <<< FRAC_BITS;
        lat1 = longint'($signed(w[30:0]));
        lon1 = longint'($signed(w[62:31]));
        lat2 = longint'($signed(w[93:63]));
        lon2 = longint'($signed(w[125:94]));
        sincos_units(lat2 - lat1, sa, ca);
        sincos_units(lon2 - lon1, sb, cb);
        sincos_units(2 * lat1, s1, c1);
        sincos_units(2 * lat2, s2, c2);
        h = qmul(sa, sa) + qmul(qmul(c1, c2), qmul(sb, sb));
        if (h < 0) h = 0;
        if (h > one) h = one;
        vx = qsqrt(one - h);
        vy = qsqrt(h);
        vz = 0;
        // Vectoring gathers the arcsine
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx = vx + dx; vy = vy - dy; vz = vz + atan_step[i];
            end else begin
                vx = vx - dx; vy = vy + dy; vz = vz - atan_step[i];
            end
        end
        ang = vz < 0 ? 0 : 2 * vz;
        prod = {64'd0, 64'(ang)} * {89'd0, R_Q16};
        meters = 64'(prod >> (FRAC_BITS + 16));
        if (meters > DIST_SAT) meters = DIST_SAT;
        return {7'd0, meters[DIST_W-1:0]};
    endfunction

    assign o_pending = distance_queue.size();

    // Push a prediction per input word, compare per output word
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                distance_queue.push_back(predict_distance(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (distance_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected distance word %0d", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = distance_queue.pop_front();
                    if (want !== i_m_tdata) begin
                        if (o_fail_count < 10)
                            $display("distance_m mismatch: expected %0d got %0d",
                                     want, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the haversine distance pipeline: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_ITEMS   = 400;
    localparam int LAT_MAX        = 900000000;
    localparam int LON_MAX        = 1800000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           stall_count;

    haversine_distance dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    haversine_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive output backpressure at random
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("[haversine_distance] ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Send one point pair and hold it until accepted
    task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, lon2, lat2[30:0], lon1, lat1[30:0]};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic int rand_lat();
        return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
    endfunction

    // Random pair: mostly in range, some near each other, some raw bits
    task automatic send_random_pair();
        int kind;
        int lat1;
        int lon1;
        kind = $urandom_range(7);
        lat1 = rand_lat();
        lon1 = rand_lon();
        if (kind == 0) begin
            send_pair($signed($urandom() >> 1) >>> 0 | ($urandom_range(1) ? 32'h80000000 : 0),
                      $urandom(), $urandom(), $urandom());
        end else if (kind < 3) begin
            send_pair(lat1, lon1,
                      lat1 + int'($urandom_range(2000000)) - 1000000,
                      lon1 + int'($urandom_range(2000000)) - 1000000);
        end else begin
            send_pair(lat1, lon1, rand_lat(), rand_lon());
        end
    endtask

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        i_rst_n       = 1'b0;
        stall_count   = 0;
        send_idle_pct = 6;
        recv_idle_pct = 82;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Same point, poles, antipodes, date line, range extremes
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, LON_MAX - 1, 0, -LON_MAX + 1);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(123456789, 45678901, -123456789, 45678901 - LON_MAX);
        send_pair(515000000, -1270000, 515000001, -1270000);
        send_pair(0, 0, 1, 1);
        send_pair(-1, -1, 0, 0);
        send_pair(0, 0, 0, 900000000);
        send_pair(LAT_MAX, 0, 0, 0);
        // Latitudes beyond the pole and raw field extremes
        send_pair(32'h3FFFFFFF, 32'h7FFFFFFF, 32'hC0000000, 32'h80000000);
        send_pair(32'hC0000000, 32'h80000000, 32'h3FFFFFFF, 32'h7FFFFFFF);
        send_pair(1000000000, 0, -1000000000, 0);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pair(32'h2AAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA);

        // Three idling phases over the random part
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 6;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_pair();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[haversine_distance] OK");
        end else begin
            $display("[haversine_distance] ERROR");
        end
        $finish;
    end

endmodule

[haversine_distance.f]
rtl/hav_pkg.sv
rtl/hav_cordic_cell.sv
rtl/hav_sqrt_cell.sv
rtl/haversine_distance.sv
sim/haversine_checker.sv
sim/tb_top.sv
